[design/ccr_pkg.sv]
package ccr_pkg;

  localparam int CoordW = 32;
  localparam int TInW = 16;
  localparam int CountW = 7;
  localparam int IdxInW = 6;
  localparam int AccW = 40;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                     command;
    logic [IdxInW-1:0]        point_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [TInW-1:0]          global_t;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] deriv_x;
    logic signed [CoordW-1:0] deriv_y;
    logic signed [CoordW-1:0] deriv_z;
  } out_item_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - AccW'(1);
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

endpackage

[design/ccr_if.sv]
interface ccr_in_if;
  logic              valid;
  logic              ready;
  ccr_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ccr_out_if;
  logic               valid;
  logic               ready;
  ccr_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/ccr_ram.sv]
module ccr_ram #(
  parameter int Width = 96,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[design/ccr_axis.sv]
// One coordinate axis of the Horner evaluation, stages 5 to 12 of the pipeline.
module ccr_axis #(
  parameter int FracBits = 16
) (
  input  logic                              clk,
  input  logic [7:0]                        en,
  input  logic signed [ccr_pkg::CoordW-1:0] p0,
  input  logic signed [ccr_pkg::CoordW-1:0] p1,
  input  logic signed [ccr_pkg::CoordW-1:0] p2,
  input  logic signed [ccr_pkg::CoordW-1:0] p3,
  input  logic [FracBits:0]                 t,
  output logic signed [ccr_pkg::CoordW-1:0] pos,
  output logic signed [ccr_pkg::CoordW-1:0] deriv
);
  localparam int AW = ccr_pkg::AccW;
  localparam int PW = AW + FracBits + 1;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (FracBits - 1);

  logic signed [AW-1:0] b0, b1, b2, b3;
  logic signed [AW-1:0] h1, g1, b1a, b2a, b3a, b2b, b3b;
  logic signed [AW-1:0] h2, g2, b2c, b3c, b3d;
  logic signed [AW-1:0] h3, g3, g4, b3e;
  logic signed [PW-1:0] hp1, gp1, hp2, gp2, hp3;
  logic signed [AW-1:0] s0, s1, s2, s3;
  // local parameter travels with its item
  logic [FracBits:0]    ta, tb, tc, td, te;

  assign s0 = AW'(p0);
  assign s1 = AW'(p1);
  assign s2 = AW'(p2);
  assign s3 = AW'(p3);

  function automatic logic signed [PW-1:0] tw(input logic [FracBits:0] v);
    return PW'(signed'({1'b0, v}));
  endfunction

  function automatic logic signed [AW-1:0] rnd(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] y;
    y = (x + Half) >>> FracBits;
    return y[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b0 <= -s0 + 3 * s1 - 3 * s2 + s3;
      b1 <= 2 * s0 - 5 * s1 + 4 * s2 - s3;
      b2 <= s2 - s0;
      b3 <= 2 * s1;
      ta <= t;
    end
    if (en[1]) begin
      hp1 <= PW'(b0) * tw(ta);
      gp1 <= PW'(3 * b0) * tw(ta);
      b1a <= b1;
      b2a <= b2;
      b3a <= b3;
      tb  <= ta;
    end
    if (en[2]) begin
      h1  <= rnd(hp1) + b1a;
      g1  <= rnd(gp1) + 2 * b1a;
      b2b <= b2a;
      b3b <= b3a;
      tc  <= tb;
    end
    if (en[3]) begin
      hp2 <= PW'(h1) * tw(tc);
      gp2 <= PW'(g1) * tw(tc);
      b2c <= b2b;
      b3c <= b3b;
      td  <= tc;
    end
    if (en[4]) begin
      h2  <= rnd(hp2) + b2c;
      g2  <= rnd(gp2) + b2c;
      b3d <= b3c;
      te  <= td;
    end
    if (en[5]) begin
      hp3 <= PW'(h2) * tw(te);
      g3  <= g2;
      b3e <= b3d;
    end
    if (en[6]) begin
      h3 <= rnd(hp3) + b3e;
      g4 <= g3;
    end
    if (en[7]) begin
      pos   <= ccr_pkg::sat32((h3 + AW'(1)) >>> 1);
      deriv <= ccr_pkg::sat32((g4 + AW'(1)) >>> 1);
    end
  end
endmodule

[design/closed_catmull_rom_evaluator.sv]
// channel | dir  | beat contents
// in_ch   | sink | command, point_index, coord_x/y/z, global_t
// out_ch  | src  | pos_x/y/z, deriv_x/y/z
// cfg     | sink | cfg_we, cfg_wdata (loop length)
// One item enters per cycle unless out_ch stalls. Twelve register stages: an evaluate beat
// is shown on out_ch when it reaches the last of them.
// Four stages scale t and fetch the four neighbours through one RAM per neighbour,
// eight more run the Horner multiplies, each followed by rounding.
// A load is written one stage after it is taken, so an earlier evaluate still sees old data.
// Reset clears valid bits and sets loop_len to 4; the point table is not cleared.
// A stall on out_ch freezes the whole pipeline; nothing is lost or repeated.
module closed_catmull_rom_evaluator #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ccr_pkg::CountW-1:0]   cfg_wdata,
  ccr_in_if.sink                       in_ch,
  ccr_out_if.source                    out_ch
);
  localparam int AddrW = $clog2(MAX_POINTS);
  localparam int NW = AddrW + 1;
  localparam int PW = ccr_pkg::TInW + NW;
  localparam int RowW = 3 * ccr_pkg::CoordW;
  localparam int Depth = 12;

  logic [ccr_pkg::CountW-1:0] loop_len;
  logic [Depth-1:0] vld;
  logic adv;
  logic [NW-1:0] n;

  ccr_pkg::in_item_t in_d;
  assign in_d = in_ch.data;
  assign adv = out_ch.ready || !vld[Depth-1];
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_len <= ccr_pkg::CountW'(4);
    end else if (cfg_we) begin
      loop_len <= cfg_wdata;
    end
  end

  always_comb begin
    if (loop_len == '0) begin
      n = NW'(1);
    end else if (32'(loop_len) > MAX_POINTS) begin
      n = NW'(MAX_POINTS);
    end else begin
      n = NW'(loop_len);
    end
  end

  // Stage 1: product of t and count.
  logic [PW-1:0] prod;
  logic [NW-1:0] n1;
  // Stage 2: segment index and neighbour indices.
  logic [AddrW-1:0] ia, ib, ic, id;
  logic [ccr_pkg::TInW-1:0] frac2;
  logic [ccr_pkg::TInW-1:0] frac3;
  logic [NW-1:0] segw, i0, i1, i2, i3;

  always_comb begin
    segw = prod[PW-1:ccr_pkg::TInW];
    i1 = segw;
    i0 = (segw == '0) ? n1 - NW'(1) : segw - NW'(1);
    i2 = (segw + NW'(1) >= n1) ? segw + NW'(1) - n1 : segw + NW'(1);
    i3 = (i2 + NW'(1) >= n1) ? i2 + NW'(1) - n1 : i2 + NW'(1);
  end

  logic wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [RowW-1:0] wr_row;
  assign wr_en = in_ch.valid && adv && (in_d.command == ccr_pkg::CMD_LOAD)
                 && (32'(in_d.point_index) < MAX_POINTS);
  assign wr_addr = AddrW'(in_d.point_index);
  assign wr_row = {in_d.coord_x, in_d.coord_y, in_d.coord_z};

  // register a load in wr_q before the RAM write so a read already in flight sees the old row
  logic wr_q;
  logic [AddrW-1:0] wr_q_addr;
  logic [RowW-1:0] wr_q_row;
  logic ram_we;
  assign ram_we = wr_q && adv;

  logic [RowW-1:0] r0, r1, r2, r3;
  ccr_ram #(.Width(RowW), .Depth(MAX_POINTS)) u_ram0 (
    .clk, .we(ram_we), .waddr(wr_q_addr), .wdata(wr_q_row), .re(adv), .raddr(ia), .rdata(r0));
  ccr_ram #(.Width(RowW), .Depth(MAX_POINTS)) u_ram1 (
    .clk, .we(ram_we), .waddr(wr_q_addr), .wdata(wr_q_row), .re(adv), .raddr(ib), .rdata(r1));
  ccr_ram #(.Width(RowW), .Depth(MAX_POINTS)) u_ram2 (
    .clk, .we(ram_we), .waddr(wr_q_addr), .wdata(wr_q_row), .re(adv), .raddr(ic), .rdata(r2));
  ccr_ram #(.Width(RowW), .Depth(MAX_POINTS)) u_ram3 (
    .clk, .we(ram_we), .waddr(wr_q_addr), .wdata(wr_q_row), .re(adv), .raddr(id), .rdata(r3));

  logic [RowW-1:0] q0, q1, q2, q3;
  logic [FRAC_BITS:0] tq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      wr_q <= 1'b0;
    end else if (adv) begin
      vld  <= {vld[Depth-2:0], in_ch.valid && (in_d.command == ccr_pkg::CMD_EVAL)};
      wr_q <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr_q_addr <= wr_addr;
      wr_q_row  <= wr_row;
      prod  <= PW'(in_d.global_t) * PW'(n);
      n1    <= n;
      ia    <= i0[AddrW-1:0];
      ib    <= i1[AddrW-1:0];
      ic    <= i2[AddrW-1:0];
      id    <= i3[AddrW-1:0];
      frac2 <= prod[ccr_pkg::TInW-1:0];
      frac3 <= frac2;
      q0 <= r0;
      q1 <= r1;
      q2 <= r2;
      q3 <= r3;
      if (FRAC_BITS >= ccr_pkg::TInW) begin
        tq <= (FRAC_BITS+1)'(frac3) << (FRAC_BITS - ccr_pkg::TInW);
      end else begin
        tq <= (FRAC_BITS+1)'(frac3 >> (ccr_pkg::TInW - FRAC_BITS));
      end
    end
  end

  // stage 4 registers q*; axes run stages 5 to 12
  logic [7:0] en;
  assign en = {8{adv}};

  ccr_pkg::out_item_t res;
  ccr_axis #(.FracBits(FRAC_BITS)) u_ax (
    .clk, .en, .p0(q0[3*32-1:2*32]), .p1(q1[3*32-1:2*32]), .p2(q2[3*32-1:2*32]),
    .p3(q3[3*32-1:2*32]), .t(tq), .pos(res.pos_x), .deriv(res.deriv_x));
  ccr_axis #(.FracBits(FRAC_BITS)) u_ay (
    .clk, .en, .p0(q0[2*32-1:32]), .p1(q1[2*32-1:32]), .p2(q2[2*32-1:32]),
    .p3(q3[2*32-1:32]), .t(tq), .pos(res.pos_y), .deriv(res.deriv_y));
  ccr_axis #(.FracBits(FRAC_BITS)) u_az (
    .clk, .en, .p0(q0[31:0]), .p1(q1[31:0]), .p2(q2[31:0]),
    .p3(q3[31:0]), .t(tq), .pos(res.pos_z), .deriv(res.deriv_z));

  assign out_ch.valid = vld[Depth-1];
  assign out_ch.data  = res;
endmodule

[design/ccr_checker.sv]
module ccr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input ccr_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out beat dropped");
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("output valid after reset");
endmodule

bind closed_catmull_rom_evaluator ccr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

[bench/closed_catmull_rom_evaluator_tb.sv]
`timescale 1ns / 1ps

module closed_catmull_rom_evaluator_tb;

  localparam int Slots = 64;
  localparam int FracW = 16;
  localparam int PipeDepth = 12;

  typedef struct {
    ccr_pkg::in_item_t  item;
    bit                 known;
    ccr_pkg::out_item_t known_out;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ccr_pkg::CountW-1:0] cfg_wdata;

  ccr_in_if  in_ch ();
  ccr_out_if out_ch ();

  closed_catmull_rom_evaluator dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // predictor state
  longint          curve_pts[Slots][3];
  bit              slot_loaded[Slots];
  logic [ccr_pkg::CountW-1:0] loop_count;

  ccr_pkg::out_item_t curve_queue[$];
  int        mismatches = 0;
  int        evals_seen = 0;
  int        loads_sent;
  int        burst_left;
  int        stall_mode = 0;
  int        stall_phase = 1;
  dir_row_t  dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int eff_count(logic [ccr_pkg::CountW-1:0] raw);
    if (raw < 1) return 1;
    if (raw > Slots) return Slots;
    return int'(raw);
  endfunction

  function automatic void neighbour_slots(logic [ccr_pkg::TInW-1:0] t, output int idx[4],
                                          output longint frac);
    int n;
    int seg;
    int prod;
    n = eff_count(loop_count);
    prod = int'(t) * n;
    seg = prod >> ccr_pkg::TInW;
    frac = longint'(prod & 32'hFFFF);
    idx[0] = (seg + n - 1) % n;
    for (int j = 1; j < 4; j++) idx[j] = (idx[j-1] + 1) % n;
  endfunction

  function automatic longint round_half_up(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [ccr_pkg::CoordW-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[ccr_pkg::CoordW-1:0];
  endfunction

  function automatic ccr_pkg::out_item_t eval_curve(logic [ccr_pkg::TInW-1:0] t);
    ccr_pkg::out_item_t r;
    int idx[4];
    longint frac;
    longint p0, p1, p2, p3, b0, b1, b2, b3, h, g;
    neighbour_slots(t, idx, frac);
    for (int c = 0; c < 3; c++) begin
      p0 = curve_pts[idx[0]][c];
      p1 = curve_pts[idx[1]][c];
      p2 = curve_pts[idx[2]][c];
      p3 = curve_pts[idx[3]][c];
      b0 = -p0 + 3 * p1 - 3 * p2 + p3;
      b1 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      b2 = -p0 + p2;
      b3 = 2 * p1;
      h = round_half_up(b0 * frac, FracW) + b1;
      h = round_half_up(h * frac, FracW) + b2;
      h = round_half_up(h * frac, FracW) + b3;
      g = round_half_up(3 * b0 * frac, FracW) + 2 * b1;
      g = round_half_up(g * frac, FracW) + b2;
      case (c)
        0: begin
          r.pos_x = clamp32(round_half_up(h, 1));
          r.deriv_x = clamp32(round_half_up(g, 1));
        end
        1: begin
          r.pos_y = clamp32(round_half_up(h, 1));
          r.deriv_y = clamp32(round_half_up(g, 1));
        end
        default: begin
          r.pos_z = clamp32(round_half_up(h, 1));
          r.deriv_z = clamp32(round_half_up(g, 1));
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [ccr_pkg::CoordW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1: return $urandom;
      default: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
    endcase
  endfunction

  function automatic ccr_pkg::in_item_t point_item(int slot,
                                                   logic signed [ccr_pkg::CoordW-1:0] x,
                                                   logic signed [ccr_pkg::CoordW-1:0] y,
                                                   logic signed [ccr_pkg::CoordW-1:0] z);
    ccr_pkg::in_item_t it;
    it.command = ccr_pkg::CMD_LOAD;
    it.point_index = slot[ccr_pkg::IdxInW-1:0];
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.global_t = ccr_pkg::TInW'($urandom);
    return it;
  endfunction

  function automatic ccr_pkg::in_item_t eval_item(logic [ccr_pkg::TInW-1:0] t);
    ccr_pkg::in_item_t it;
    it.command = ccr_pkg::CMD_EVAL;
    it.point_index = ccr_pkg::IdxInW'($urandom);
    it.coord_x = $urandom;
    it.coord_y = $urandom;
    it.coord_z = $urandom;
    it.global_t = t;
    return it;
  endfunction

  // hold the beat until taken, then update the table or queue the expected point
  task automatic send_item(ccr_pkg::in_item_t it, bit known = 1'b0,
                           ccr_pkg::out_item_t known_out = '0);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.data <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (it.command == ccr_pkg::CMD_LOAD) begin
      curve_pts[it.point_index][0] = longint'(it.coord_x);
      curve_pts[it.point_index][1] = longint'(it.coord_y);
      curve_pts[it.point_index][2] = longint'(it.coord_z);
      slot_loaded[it.point_index] = 1'b1;
      loads_sent++;
    end else begin
      curve_queue.push_back(known ? known_out : eval_curve(it.global_t));
    end
  endtask

  task automatic set_count(logic [ccr_pkg::CountW-1:0] v);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (curve_queue.size() != 0) @(posedge clk);
    repeat (PipeDepth + 6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    loop_count = v;
  endtask

  task automatic check_field(string name, logic signed [ccr_pkg::CoordW-1:0] exp_v,
                             logic signed [ccr_pkg::CoordW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // receiver stall pattern: always ready, random, or one beat in four
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 97 == 0) begin
      stall_mode <= $urandom_range(0, 2);
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= (stall_phase % 4 == 0);
    endcase
  end

  always @(posedge clk) begin
    ccr_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (curve_queue.size() == 0) begin
        $error("unexpected result beat");
        mismatches++;
      end else begin
        want = curve_queue.pop_front();
        evals_seen++;
        check_field("pos_x", want.pos_x, out_ch.data.pos_x);
        check_field("pos_y", want.pos_y, out_ch.data.pos_y);
        check_field("pos_z", want.pos_z, out_ch.data.pos_z);
        check_field("deriv_x", want.deriv_x, out_ch.data.deriv_x);
        check_field("deriv_y", want.deriv_y, out_ch.data.deriv_y);
        check_field("deriv_z", want.deriv_z, out_ch.data.deriv_z);
      end
    end
  end

  initial begin
    logic [ccr_pkg::CountW-1:0] counts[$];
    dir_row_t row;
    ccr_pkg::in_item_t it;
    int idx[4];
    longint frac;
    int missing;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    loads_sent = 0;
    burst_left = 0;
    loop_count = 4;
    for (int i = 0; i < Slots; i++) begin
      slot_loaded[i] = 1'b0;
      for (int c = 0; c < 3; c++) curve_pts[i][c] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // equal points: the curve sits on the point with no slope
    for (int s = 0; s < 4; s++) begin
      row.item = point_item(s, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
      row.known = 1'b0;
      dir_rows.push_back(row);
    end
    row.known = 1'b1;
    row.known_out = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    row.item = eval_item(16'h0000);
    dir_rows.push_back(row);
    row.item = eval_item(16'hFFFF);
    dir_rows.push_back(row);
    // alternating extremes in x, a ramp in y; at t = 0 the curve sits on point 0
    for (int s = 0; s < 4; s++) begin
      row.item = point_item(s, s[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                            32'sh0001_0000 * s, 32'sh0);
      row.known = 1'b0;
      dir_rows.push_back(row);
    end
    row.known = 1'b1;
    row.known_out = '{32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0, 32'shFFFF_0000, 32'sh0};
    row.item = eval_item(16'h0000);
    dir_rows.push_back(row);
    row.known = 1'b0;
    row.item = eval_item(16'h8000);
    dir_rows.push_back(row);
    row.item = eval_item(16'hFFFF);
    dir_rows.push_back(row);
    row.item = eval_item(16'h4000);
    dir_rows.push_back(row);
    row.item = eval_item(16'h3FFF);
    dir_rows.push_back(row);
    row.item = eval_item(16'h0001);
    dir_rows.push_back(row);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].known_out);

    counts = '{7'd1, 7'd0, 7'd2, 7'd3, 7'd64, 7'd127, 7'd65, 7'd4,
               7'($urandom_range(5, 63)), 7'($urandom_range(1, 127))};
    foreach (counts[p]) begin
      set_count(counts[p]);
      for (int k = 0; k < 40; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          it = point_item($urandom_range(0, Slots - 1), rand_coord(), rand_coord(),
                          rand_coord());
        end else begin
          case ($urandom_range(0, 7))
            0: it = eval_item(16'h0000);
            1: it = eval_item(16'hFFFF);
            default: it = eval_item(ccr_pkg::TInW'($urandom));
          endcase
          // load a missing neighbour in place of the evaluate so no unwritten slot is read
          neighbour_slots(it.global_t, idx, frac);
          missing = -1;
          foreach (idx[j]) if (!slot_loaded[idx[j]]) missing = idx[j];
          if (missing >= 0) it = point_item(missing, rand_coord(), rand_coord(), rand_coord());
        end
        send_item(it);
      end
    end

    in_ch.valid <= 1'b0;
    while (curve_queue.size() != 0) @(posedge clk);
    repeat (PipeDepth + 6) @(posedge clk);

    $display("Covered %0d point loads and %0d curve evaluations over %0d loop counts.",
             loads_sent, evals_seen, counts.size() + 1);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ccr_pkg.sv
design/ccr_if.sv
design/ccr_ram.sv
design/ccr_axis.sv
design/closed_catmull_rom_evaluator.sv
design/ccr_checker.sv
bench/closed_catmull_rom_evaluator_tb.sv
